### hw/rtl/sha_pkg.sv
// Package: payload types, round constants and SHA-256 helper functions.
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } core_state_t;

  // Handoff from front end to back end
  typedef struct packed {
    logic        finish;
    logic [5:0]  fill;
    logic [63:0] total_bits;
  } job_t;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sha_front.sv
// Front end: gathers message bytes into a block and queues block jobs.
`default_nettype none
module sha_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sha_pkg::in_word_t in_data,
  // job handoff
  output logic                  job_valid,
  input  wire logic             job_ready,
  output sha_pkg::job_t         job,
  output logic [511:0]          job_block
);
  logic [511:0] buffer;
  logic [5:0]   fill;
  logic [63:0]  total_bits;
  logic         pending;
  logic         accept;
  logic         full_next;

  // One job slot between the two halves; input stalls only while it is taken
  assign in_ready = !pending;
  assign accept   = in_valid && in_ready;
  assign full_next = (fill == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      total_bits <= '0;
      pending    <= 1'b0;
    end else begin
      if (job_valid && job_ready) pending <= 1'b0;
      if (accept) begin
        if (in_data.opcode == sha_pkg::OP_ABSORB) begin
          buffer[511 - 8*fill -: 8] <= in_data.data_byte;
          if (full_next) begin
            pending    <= 1'b1;
            job        <= '{finish: 1'b0, fill: 6'd0, total_bits: total_bits};
            job_block  <= {buffer[511:8], in_data.data_byte};
            total_bits <= total_bits + 64'd512;
            fill       <= '0;
          end else begin
            fill <= fill + 6'd1;
          end
        end else begin
          pending    <= 1'b1;
          job        <= '{finish: 1'b1, fill: fill, total_bits: total_bits};
          job_block  <= buffer;
          total_bits <= '0;
          fill       <= '0;
        end
      end
    end
  end

  assign job_valid = pending;

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    !(accept && pending))
    else $error("accept with job slot full");
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready) |=> (job_valid && $stable(job)))
    else $error("job dropped or changed while waiting");
  a_fill_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && full_next) |=> (pending && fill == 6'd0))
    else $error("fill not cleared after full block");
endmodule
`default_nettype wire

### hw/rtl/sha_core.sv
// Back end: round-per-cycle compression, padding and digest output.
`default_nettype none
module sha_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire sha_pkg::job_t     job,
  input  wire logic [511:0]      job_block,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sha_pkg::out_word_t     out_data
);
  sha_pkg::core_state_t state, state_next;
  logic [255:0] hv;
  logic [255:0] v;
  logic [511:0] w;
  logic [5:0]   round;
  logic         finish;
  logic         second;   // a padding block still follows
  logic [63:0]  msg_len;
  logic [2:0]   widx;
  logic [511:0] pad_blk;
  logic [511:0] first_blk;
  logic         start;

  // Padding of the tail bytes
  always_comb begin
    first_blk = job_block;
    for (int i = 0; i < 64; i++) begin
      if (i == int'(job.fill)) first_blk[511 - 8*i -: 8] = 8'h80;
      else if (i > int'(job.fill)) first_blk[511 - 8*i -: 8] = 8'h00;
    end
    if (job.fill < 6'd56) first_blk[63:0] = job.total_bits + {55'd0, job.fill, 3'd0};
  end
  assign pad_blk = {448'd0, msg_len};

  // Round datapath
  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wn, s0, s1, wcur;
  always_comb begin
    {a, b, c, d, e, f, g, h} = v;
    wcur = w[511:480];
    t1 = h + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25)) +
         ((e & f) ^ (~e & g)) + sha_pkg::round_k(round) + wcur;
    t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22)) +
         ((a & b) ^ (a & c) ^ (b & c));
    s0 = sha_pkg::ror(w[479:448], 7) ^ sha_pkg::ror(w[479:448], 18) ^ (w[479:448] >> 3);
    s1 = sha_pkg::ror(w[63:32], 17) ^ sha_pkg::ror(w[63:32], 19) ^ (w[63:32] >> 10);
    wn = wcur + s0 + w[223:192] + s1;
  end

  assign start = (state == sha_pkg::ST_IDLE) && job_valid;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::ST_IDLE:  if (job_valid) state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (round == 6'd63) state_next = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (!finish) state_next = sha_pkg::ST_IDLE;
        else if (second) state_next = sha_pkg::ST_PAD;
        else state_next = sha_pkg::ST_EMIT;
      end
      sha_pkg::ST_PAD:   state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_EMIT:  if (out_ready && widx == 3'd7) state_next = sha_pkg::ST_IDLE;
      default:           state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    job_ready = (state == sha_pkg::ST_IDLE);
    out_valid = (state == sha_pkg::ST_EMIT);
    out_data.digest_word = hv[255:224];
    out_data.word_index  = widx;
    out_data.last_word   = (widx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      hv    <= sha_pkg::H_INIT;
      widx  <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        finish  <= job.finish;
        second  <= job.finish && (job.fill >= 6'd56);
        msg_len <= job.total_bits + {55'd0, job.fill, 3'd0};
        w       <= job.finish ? first_blk : job_block;
        v       <= hv;
        round   <= '0;
      end
      if (state == sha_pkg::ST_PAD) begin
        w      <= pad_blk;
        v      <= hv;
        round  <= '0;
        second <= 1'b0;
      end
      if (state == sha_pkg::ST_ROUND) begin
        v     <= {t1 + t2, a, b, c, d + t1, e, f, g};
        w     <= {w[479:0], wn};
        round <= round + 6'd1;
      end
      if (state == sha_pkg::ST_ADD) begin
        for (int j = 0; j < 8; j++)
          hv[255 - 32*j -: 32] <= hv[255 - 32*j -: 32] + v[255 - 32*j -: 32];
        widx <= '0;
      end
      if (state == sha_pkg::ST_EMIT && out_ready) begin
        widx <= widx + 3'd1;
        if (widx == 3'd7) hv <= sha_pkg::H_INIT;
        else hv <= {hv[223:0], hv[255:224]};
      end
    end
  end

  a_emit_not_idle: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && job_ready))
    else $error("emit while idle");
  a_emit_finish: assert property (@(posedge clk) disable iff (rst)
    (state == sha_pkg::ST_EMIT) |-> finish)
    else $error("emit without finish");
  a_pad_second: assert property (@(posedge clk) disable iff (rst)
    (state == sha_pkg::ST_PAD) |-> second)
    else $error("pad without second block");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("digest word dropped or changed while waiting");
endmodule
`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
// Timing: an absorb word is taken whenever the job slot is free; a full block occupies the
// core for a dispatch, 64 rounds and an add, one round per cycle.
// A finish takes one or two compressions (the second on a padding block), then eight digest words.
// Input stalls only while the single job slot holds a block the core has not taken.
// Reset (rst, synchronous) loads the initial hash values and clears counts.
`default_nettype none
module sha256_stream_hasher (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sha_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sha_pkg::out_word_t      out_data
);
  logic          job_valid, job_ready;
  sha_pkg::job_t job;
  logic [511:0]  job_block;

  sha_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .job_valid, .job_ready, .job, .job_block
  );

  sha_core u_core (
    .clk, .rst, .job_valid, .job_ready, .job, .job_block,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

### sim/tb_sha256_stream_hasher.sv
// Testbench: checks the SHA-256 stream hasher digests against a built-in predictor.
module tb_sha256_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  sha_pkg::in_word_t in_data = '0;
  logic in_ready, out_valid;
  sha_pkg::out_word_t out_data;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int          msg_fill;
  logic [63:0] hashed_bits;

  sha_pkg::in_word_t  pending_words [$];
  sha_pkg::out_word_t digest_queue [$];
  int  error_count = 0;
  int  words_sent = 0;
  int  digests_seen = 0;
  bit  stim_done = 1'b0;
  bit  calm_phase = 1'b0;
  bit  hold_request = 1'b0;
  bit  in_accepted = 1'b0;
  int  idle_cycles = 0;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Fold msg_block into hash_state
  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int j = 16; j < 64; j++) begin
      s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = w[j-16] + s0 + w[j-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           K_TAB[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart_hash();
    for (int j = 0; j < 8; j++) hash_state[j] = sha_pkg::H_INIT[255 - 32*j -: 32];
    msg_fill = 0;
    hashed_bits = '0;
  endtask

  // Advance the predictor by one accepted word
  task automatic predict_digest(sha_pkg::in_word_t w);
    logic [63:0] bit_len;
    sha_pkg::out_word_t o;
    if (w.opcode == sha_pkg::OP_ABSORB) begin
      msg_block[msg_fill] = w.data_byte;
      msg_fill++;
      if (msg_fill == 64) begin
        compress_msg_block();
        hashed_bits += 64'd512;
        msg_fill = 0;
      end
    end else begin
      bit_len = hashed_bits + 64'(msg_fill * 8);
      msg_block[msg_fill] = 8'h80;
      for (int i = msg_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (msg_fill >= 56) begin
        compress_msg_block();
        for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[63 - i] = bit_len[8*i +: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_state[i];
        o.word_index = 3'(i);
        o.last_word = (i == 7);
        digest_queue.push_back(o);
      end
      restart_hash();
    end
  endtask

  task automatic queue_message(int len, bit close);
    sha_pkg::in_word_t w;
    for (int i = 0; i < len; i++) begin
      w.opcode = sha_pkg::OP_ABSORB;
      w.data_byte = 8'($urandom_range(0, 255));
      pending_words.push_back(w);
    end
    if (close) begin
      w.opcode = sha_pkg::OP_FINISH;
      w.data_byte = 8'($urandom_range(0, 255));
      pending_words.push_back(w);
    end
  endtask

  // Driver: offers pending words, with random gaps outside the calm phase
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // hold the offered word
    end else begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0 &&
                   (calm_phase || hold_request || $urandom_range(0, 9) != 0)) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (!calm_phase && !hold_request) send_gap = $urandom_range(1, 15);
      end
    end
  end

  // Receiver readiness: random stall bursts, plus one long hold-off
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request && hold_left == 0 && !out_ready && stall_left < 0) begin
      out_ready <= 1'b1;
    end else begin
      if (hold_request && hold_left == 0 && stall_left >= 0) begin
        hold_left = 600;
        stall_left = -1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (stall_left < 0) stall_left = 0;
        if (!calm_phase && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 15);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) begin
        predict_digest(in_data);
        words_sent++;
      end
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          $error("unexpected digest word %h", out_data.digest_word);
          error_count++;
        end else begin
          sha_pkg::out_word_t exp_w;
          exp_w = digest_queue.pop_front();
          if (out_data.digest_word !== exp_w.digest_word) begin
            $error("digest_word expected %h actual %h",
                   exp_w.digest_word, out_data.digest_word);
            error_count++;
          end
          if (out_data.word_index !== exp_w.word_index) begin
            $error("word_index expected %0d actual %0d", exp_w.word_index, out_data.word_index);
            error_count++;
          end
          if (out_data.last_word !== exp_w.last_word) begin
            $error("last_word expected %0d actual %0d", exp_w.last_word, out_data.last_word);
            error_count++;
          end
          if (exp_w.last_word) digests_seen++;
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    sha_pkg::in_word_t w;
    restart_hash();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, back-to-back finishes, extreme bytes
    w.opcode = sha_pkg::OP_FINISH; w.data_byte = 8'hff;
    pending_words.push_back(w);
    pending_words.push_back(w);
    w.opcode = sha_pkg::OP_ABSORB; w.data_byte = 8'h00; pending_words.push_back(w);
    w.data_byte = 8'hff; pending_words.push_back(w);
    w.data_byte = 8'h55; pending_words.push_back(w);
    w.data_byte = 8'haa; pending_words.push_back(w);
    w.opcode = sha_pkg::OP_FINISH; w.data_byte = 8'h00; pending_words.push_back(w);
    // Padding boundaries: 55, 56 and 64 bytes pending / absorbed
    queue_message(55, 1);
    queue_message(56, 1);
    queue_message(64, 1);
    wait (pending_words.size() == 0 && !in_valid && digest_queue.size() == 0);

    // Long receiver hold-off while the sender keeps offering
    queue_message(100, 1);
    queue_message(3, 1);
    hold_request = 1'b1;
    wait (hold_left > 0);
    wait (hold_left == 0);
    hold_request = 1'b0;
    wait (pending_words.size() == 0 && !in_valid && digest_queue.size() == 0);

    // Random messages, mostly short, some spanning several blocks
    for (int m = 0; m < 4; m++)
      queue_message(($urandom_range(0, 5) == 0) ? $urandom_range(56, 140)
                                                : $urandom_range(0, 40), 1);
    wait (pending_words.size() == 0);
    calm_phase = 1'b1;
    for (int m = 0; m < 2; m++) queue_message($urandom_range(0, 70), 1);
    wait (pending_words.size() == 0 && !in_valid && digest_queue.size() == 0);
    stim_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input words and %0d digests, incl. empty, padding edges, stalls",
             words_sent, digests_seen);
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_stream_hasher.sv
sim/tb_sha256_stream_hasher.sv
